### src/rbst_pkg.sv
// Shared constants and types for the ray versus box slab test.
// No dependencies; imported by ray_box_slab_test_top, rbst_axis and tb_top.
`timescale 1ns / 1ps

package rbst_pkg;

    // Default coordinate format: signed Q16.16.
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // Width of the parallel threshold register and its value after reset.
    localparam int EPS_WIDTH = 17;
    localparam logic [EPS_WIDTH-1:0] EPS_RESET = 17'd7;

    // Width of a slab time, saturated to this signed range.
    localparam int T_BITS = 48;
    localparam logic signed [T_BITS-1:0] T_MAX = {1'b0, {(T_BITS-1){1'b1}}};
    localparam logic signed [T_BITS-1:0] T_MIN = {1'b1, {(T_BITS-1){1'b0}}};

    // Entry and exit time of one axis.
    typedef struct packed {
        logic signed [T_BITS-1:0] enter;
        logic signed [T_BITS-1:0] leave;
    } slab_t;

endpackage

### src/ray_box_slab_test_top.sv
// Top level of the ray versus axis-aligned box slab test.
// Depends on rbst_pkg, rbst_axis and rbst_div_stage.
`timescale 1ns / 1ps

//  channel   signals                                        transfer
//  command   start, busy, origin_*, dir_*, box_min_*, box_max_*   start && !busy
//  result    done, hit                                      done (one cycle)
//  config    cfg_we, cfg_wdata (epsilon)                    cfg_we
//
//  One item may be taken in every cycle; busy is always low.
//  The result follows the command transfer through the axis pipelines (a divider
//  chain of one quotient bit per stage), the reduction steps and the final compare.
//  rst_n clears the valid bits and sets epsilon to 7; data registers keep no reset.
//  The receiver cannot stall, so the pipeline advances on every clock.

module ray_box_slab_test_top
    import rbst_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] origin_x,
    input  logic signed [COORD_WIDTH-1:0] origin_y,
    input  logic signed [COORD_WIDTH-1:0] origin_z,
    input  logic signed [COORD_WIDTH-1:0] dir_x,
    input  logic signed [COORD_WIDTH-1:0] dir_y,
    input  logic signed [COORD_WIDTH-1:0] dir_z,
    input  logic signed [COORD_WIDTH-1:0] box_min_x,
    input  logic signed [COORD_WIDTH-1:0] box_min_y,
    input  logic signed [COORD_WIDTH-1:0] box_min_z,
    input  logic signed [COORD_WIDTH-1:0] box_max_x,
    input  logic signed [COORD_WIDTH-1:0] box_max_y,
    input  logic signed [COORD_WIDTH-1:0] box_max_z,
    input  logic                          cfg_we,
    input  logic        [EPS_WIDTH-1:0]   cfg_wdata,
    output logic                          done,
    output logic                          hit
);

    // Axis latency is two front stages, the divider chain, saturation and ordering.
    localparam int AXIS_LAT = COORD_WIDTH + 1 + FRAC_BITS + 4;
    localparam int LAT      = AXIS_LAT + 3;

    assign busy = 1'b0;

    // Parallel threshold register.
    logic [EPS_WIDTH-1:0] epsilon_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            epsilon_reg <= EPS_RESET;
        else if (cfg_we)
            epsilon_reg <= cfg_wdata;
    end

    // Valid bits that follow the data down the pipeline.
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    always_comb
    begin
        vld_next = {vld_reg[LAT-2:0], start & ~busy};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // Three axis pipelines in lockstep.
    slab_t sx, sy, sz;

    rbst_axis #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_axis_x (
        .clk (clk), .origin (origin_x), .dir (dir_x),
        .bmin (box_min_x), .bmax (box_max_x), .epsilon (epsilon_reg), .slab (sx)
    );

    rbst_axis #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_axis_y (
        .clk (clk), .origin (origin_y), .dir (dir_y),
        .bmin (box_min_y), .bmax (box_max_y), .epsilon (epsilon_reg), .slab (sy)
    );

    rbst_axis #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_axis_z (
        .clk (clk), .origin (origin_z), .dir (dir_z),
        .bmin (box_min_z), .bmax (box_max_z), .epsilon (epsilon_reg), .slab (sz)
    );

    // First reduction step: combine x and y, carry z along.
    slab_t r1_reg, z1_reg;

    always_ff @(posedge clk)
    begin
        r1_reg.enter <= (sy.enter > sx.enter) ? sy.enter : sx.enter;
        r1_reg.leave <= (sy.leave < sx.leave) ? sy.leave : sx.leave;
        z1_reg       <= sz;
    end

    // Second reduction step: fold in z.
    slab_t r2_reg;

    always_ff @(posedge clk)
    begin
        r2_reg.enter <= (z1_reg.enter > r1_reg.enter) ? z1_reg.enter : r1_reg.enter;
        r2_reg.leave <= (z1_reg.leave < r1_reg.leave) ? z1_reg.leave : r1_reg.leave;
    end

    // Final compare of the latest entry against the earliest exit.
    logic hit_reg;

    always_ff @(posedge clk)
    begin
        hit_reg <= (r2_reg.enter <= r2_reg.leave);
    end

    assign hit  = hit_reg;
    assign done = vld_reg[LAT-1];

    // Every command transfer yields exactly one result after the fixed latency.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("command transfer without result at fixed latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result strobe without matching command transfer");

    // The threshold changes only on a configuration write.
    a_eps_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(cfg_we) |-> $stable(epsilon_reg))
        else $error("epsilon changed without a write");

endmodule

### src/rbst_div_stage.sv
// One registered step of the pipelined restoring divider: one quotient bit.
// Depends on rbst_pkg only by convention; no package items are needed.
`timescale 1ns / 1ps

module rbst_div_stage #(
    parameter int DW = 32,
    parameter int QW = 49
) (
    input  logic          clk,
    input  logic [DW-1:0] divisor,
    input  logic [DW-1:0] rem_in,
    input  logic [QW-1:0] acc_in,
    output logic [DW-1:0] rem_out,
    output logic [QW-1:0] acc_out
);

    logic [DW:0]   trial;
    logic          ge;
    logic [DW:0]   diff;
    logic [DW-1:0] rem_next;
    logic [QW-1:0] acc_next;
    logic [DW-1:0] rem_reg;
    logic [QW-1:0] acc_reg;

    // Bring down the next dividend bit and try a subtraction.
    // The accumulator shifts dividend bits out on top and quotient bits in below.
    always_comb
    begin
        trial    = {rem_in, acc_in[QW-1]};
        ge       = (trial >= {1'b0, divisor});
        diff     = trial - {1'b0, divisor};
        rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
        acc_next = {acc_in[QW-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        acc_reg <= acc_next;
    end

    assign rem_out = rem_reg;
    assign acc_out = acc_reg;

endmodule

### src/rbst_axis.sv
// Slab times for one axis: numerators, parallel check, divider chain, saturation, ordering.
// Depends on rbst_pkg and rbst_div_stage.
`timescale 1ns / 1ps

module rbst_axis
    import rbst_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic signed [COORD_WIDTH-1:0] origin,
    input  logic signed [COORD_WIDTH-1:0] dir,
    input  logic signed [COORD_WIDTH-1:0] bmin,
    input  logic signed [COORD_WIDTH-1:0] bmax,
    input  logic        [EPS_WIDTH-1:0]   epsilon,
    output slab_t                         slab
);

    localparam int NW  = COORD_WIDTH + 1;
    localparam int QW  = NW + FRAC_BITS;
    localparam int QXW = QW + T_BITS;
    localparam int EXW = COORD_WIDTH + EPS_WIDTH;
    localparam logic signed [T_BITS-1:0] T_FAR = T_BITS'(64'd1000000 << FRAC_BITS);
    localparam logic [QXW-1:0] SAT_LIM = QXW'(1) << (T_BITS - 1);

    // Sign and selection bits that travel beside the divider.
    typedef struct packed {
        logic par;
        logic neg0;
        logic neg1;
        logic pos0;
        logic pos1;
    } side_t;

    // First stage: numerators, divisor magnitude and the parallel flag.
    logic signed [NW-1:0]          n0_reg, n1_reg;
    logic        [COORD_WIDTH-1:0] dmag_reg;
    logic                          dneg_reg;
    logic                          par_reg;
    logic        [COORD_WIDTH-1:0] dmag_next;

    always_comb
    begin
        dmag_next = dir[COORD_WIDTH-1] ? COORD_WIDTH'(-dir) : COORD_WIDTH'(dir);
    end

    always_ff @(posedge clk)
    begin
        n0_reg   <= NW'(bmin) - NW'(origin);
        n1_reg   <= NW'(bmax) - NW'(origin);
        dmag_reg <= dmag_next;
        dneg_reg <= dir[COORD_WIDTH-1];
        par_reg  <= (dmag_next == '0) || (EXW'(dmag_next) < EXW'(epsilon));
    end

    // Second stage: numerator magnitudes scaled into dividends.
    logic [NW-1:0]          nmag0, nmag1;
    logic [QW-1:0]          acc0_init_reg, acc1_init_reg;
    logic [COORD_WIDTH-1:0] div_init_reg;
    side_t                  side_init_reg;

    always_comb
    begin
        nmag0 = n0_reg[NW-1] ? NW'(-n0_reg) : NW'(n0_reg);
        nmag1 = n1_reg[NW-1] ? NW'(-n1_reg) : NW'(n1_reg);
    end

    always_ff @(posedge clk)
    begin
        acc0_init_reg      <= {nmag0, {FRAC_BITS{1'b0}}};
        acc1_init_reg      <= {nmag1, {FRAC_BITS{1'b0}}};
        div_init_reg       <= dmag_reg;
        side_init_reg.par  <= par_reg;
        side_init_reg.neg0 <= n0_reg[NW-1] ^ dneg_reg;
        side_init_reg.neg1 <= n1_reg[NW-1] ^ dneg_reg;
        side_init_reg.pos0 <= ~n0_reg[NW-1];
        side_init_reg.pos1 <= ~n1_reg[NW-1];
    end

    // Divider chain: one quotient bit per stage for both numerators.
    logic [COORD_WIDTH-1:0] rem0 [QW+1];
    logic [COORD_WIDTH-1:0] rem1 [QW+1];
    logic [QW-1:0]          acc0 [QW+1];
    logic [QW-1:0]          acc1 [QW+1];
    logic [COORD_WIDTH-1:0] div  [QW+1];
    side_t                  side [QW+1];

    assign rem0[0] = '0;
    assign rem1[0] = '0;
    assign acc0[0] = acc0_init_reg;
    assign acc1[0] = acc1_init_reg;
    assign div[0]  = div_init_reg;
    assign side[0] = side_init_reg;

    for (genvar s = 0; s < QW; s++)
    begin : g_div
        logic [COORD_WIDTH-1:0] div_reg;
        side_t                  side_reg;

        rbst_div_stage #(.DW(COORD_WIDTH), .QW(QW)) u_lane0 (
            .clk     (clk),
            .divisor (div[s]),
            .rem_in  (rem0[s]),
            .acc_in  (acc0[s]),
            .rem_out (rem0[s+1]),
            .acc_out (acc0[s+1])
        );

        rbst_div_stage #(.DW(COORD_WIDTH), .QW(QW)) u_lane1 (
            .clk     (clk),
            .divisor (div[s]),
            .rem_in  (rem1[s]),
            .acc_in  (acc1[s]),
            .rem_out (rem1[s+1]),
            .acc_out (acc1[s+1])
        );

        always_ff @(posedge clk)
        begin
            div_reg  <= div[s];
            side_reg <= side[s];
        end

        assign div[s+1]  = div_reg;
        assign side[s+1] = side_reg;
    end

    // Saturation and sign, or the far value on a parallel axis.
    function automatic logic signed [T_BITS-1:0] to_time(
        input logic [QW-1:0] q,
        input logic          neg,
        input logic          pos,
        input logic          par
    );
        logic [QXW-1:0] qx;
        logic signed [T_BITS-1:0] r;
        qx = QXW'(q);
        if (par)
            r = pos ? T_FAR : -T_FAR;
        else if (qx >= SAT_LIM)
            r = neg ? T_MIN : T_MAX;
        else if (neg)
            r = -$signed(qx[T_BITS-1:0]);
        else
            r = $signed(qx[T_BITS-1:0]);
        return r;
    endfunction

    logic signed [T_BITS-1:0] t0_reg, t1_reg;

    always_ff @(posedge clk)
    begin
        t0_reg <= to_time(acc0[QW], side[QW].neg0, side[QW].pos0, side[QW].par);
        t1_reg <= to_time(acc1[QW], side[QW].neg1, side[QW].pos1, side[QW].par);
    end

    // Order the pair so that entry does not exceed exit.
    slab_t slab_reg;

    always_ff @(posedge clk)
    begin
        if (t0_reg > t1_reg)
        begin
            slab_reg.enter <= t1_reg;
            slab_reg.leave <= t0_reg;
        end
        else
        begin
            slab_reg.enter <= t0_reg;
            slab_reg.leave <= t1_reg;
        end
    end

    assign slab = slab_reg;

endmodule

### bench/tb_top.sv
// Self-checking testbench for the ray versus axis-aligned box slab test.
// Depends on rbst_pkg and ray_box_slab_test_top; predicts hit per item.
`timescale 1ns / 1ps

module tb_top;
    import rbst_pkg::*;

    localparam int CW        = COORD_WIDTH_DEF;
    localparam int FB        = FRAC_BITS_DEF;
    localparam int LATENCY   = CW + FB + 8;
    localparam int CYCLE_CAP = 400000;
    localparam longint T_FAR = 64'sd1000000 <<< FB;

    typedef struct {
        logic signed [CW-1:0] org [3];
        logic signed [CW-1:0] dir [3];
        logic signed [CW-1:0] lo  [3];
        logic signed [CW-1:0] hi  [3];
    } ray_box_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [CW-1:0] org_d [3];
    logic signed [CW-1:0] dir_d [3];
    logic signed [CW-1:0] lo_d  [3];
    logic signed [CW-1:0] hi_d  [3];
    logic cfg_we = 1'b0;
    logic [EPS_WIDTH-1:0] cfg_wdata = '0;
    logic done;
    logic hit;

    ray_box_t pending_rays [$];
    bit       hit_expected [$];
    logic [EPS_WIDTH-1:0] eps_model = EPS_RESET;
    int idle_pct = 0;
    int errors = 0;
    int hits_seen = 0;
    int results_seen = 0;
    int cycles = 0;

    initial
    begin
        for (int a = 0; a < 3; a++)
        begin
            org_d[a] = '0; dir_d[a] = '0; lo_d[a] = '0; hi_d[a] = '0;
        end
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ray_box_slab_test_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .origin_x(org_d[0]), .origin_y(org_d[1]), .origin_z(org_d[2]),
        .dir_x(dir_d[0]), .dir_y(dir_d[1]), .dir_z(dir_d[2]),
        .box_min_x(lo_d[0]), .box_min_y(lo_d[1]), .box_min_z(lo_d[2]),
        .box_max_x(hi_d[0]), .box_max_y(hi_d[1]), .box_max_z(hi_d[2]),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .hit(hit)
    );

    // Fixed-point quotient (num << FB) / den, truncated toward zero and saturated.
    function automatic longint slab_time(longint num, longint den);
        logic [127:0] nmag;
        logic [127:0] dmag;
        logic [127:0] q;
        bit neg;
        nmag = (num < 0) ? -num : num;
        dmag = (den < 0) ? -den : den;
        neg = (num < 0) != (den < 0);
        q = (nmag << FB) / dmag;
        if (neg)
            return (q >= (128'd1 << (T_BITS - 1))) ? -(64'sd1 <<< (T_BITS - 1))
                                                   : -longint'(q);
        return (q > ((128'd1 << (T_BITS - 1)) - 1)) ? (64'sd1 <<< (T_BITS - 1)) - 1
                                                    : longint'(q);
    endfunction

    // Slab intersection over the three axes.
    function automatic bit predict_hit(ray_box_t r);
        longint t0, t1, s, dmag, tin, tout;
        tin = 0;
        tout = 0;
        for (int a = 0; a < 3; a++)
        begin
            dmag = (r.dir[a] < 0) ? -longint'(r.dir[a]) : longint'(r.dir[a]);
            if (dmag < longint'(eps_model) || dmag == 0)
            begin
                t0 = (longint'(r.lo[a]) - r.org[a] >= 0) ? T_FAR : -T_FAR;
                t1 = (longint'(r.hi[a]) - r.org[a] >= 0) ? T_FAR : -T_FAR;
            end
            else
            begin
                t0 = slab_time(longint'(r.lo[a]) - r.org[a], r.dir[a]);
                t1 = slab_time(longint'(r.hi[a]) - r.org[a], r.dir[a]);
            end
            if (t0 > t1)
            begin
                s = t0; t0 = t1; t1 = s;
            end
            if (a == 0 || t0 > tin)
                tin = t0;
            if (a == 0 || t1 < tout)
                tout = t1;
        end
        return tin <= tout;
    endfunction

    // Random coordinate: mostly moderate values, sometimes full range or edges.
    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            2: return $signed($urandom_range(0, 20)) - 10;
            default: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
        endcase
    endfunction

    function automatic ray_box_t rand_ray();
        ray_box_t r;
        for (int a = 0; a < 3; a++)
        begin
            r.org[a] = rand_coord();
            r.dir[a] = rand_coord();
            r.lo[a]  = rand_coord();
            r.hi[a]  = rand_coord();
            // Most boxes are built around the origin so that hits are common.
            if ($urandom_range(0, 2) != 0)
            begin
                r.lo[a] = r.org[a] - $signed($urandom_range(0, 32'h000fffff));
                r.hi[a] = r.org[a] + $signed($urandom_range(0, 32'h000fffff));
            end
        end
        return r;
    endfunction

    function automatic ray_box_t fill_ray(logic signed [CW-1:0] o, logic signed [CW-1:0] d,
                                          logic signed [CW-1:0] l, logic signed [CW-1:0] h);
        ray_box_t r;
        for (int a = 0; a < 3; a++)
        begin
            r.org[a] = o; r.dir[a] = d; r.lo[a] = l; r.hi[a] = h;
        end
        return r;
    endfunction

    // Driver: present one queued item per cycle unless idling.
    always @(posedge clk)
    begin
        ray_box_t r;
        cycles <= cycles + 1;
        if (pending_rays.size() != 0 && !busy &&
            $urandom_range(0, 99) >= idle_pct)
        begin
            r = pending_rays.pop_front();
            org_d <= r.org; dir_d <= r.dir; lo_d <= r.lo; hi_d <= r.hi;
            start <= 1'b1;
            hit_expected.push_back(predict_hit(r));
        end
        else
            start <= 1'b0;
    end

    // Monitor: compare each result with the oldest expectation.
    always @(posedge clk)
    begin
        bit want;
        if (rst_n && done)
        begin
            results_seen <= results_seen + 1;
            if (hit_expected.size() == 0)
            begin
                $error("unexpected result transfer: hit=%0b", hit);
                errors <= errors + 1;
            end
            else
            begin
                want = hit_expected.pop_front();
                hits_seen <= hits_seen + hit;
                if (hit !== want)
                begin
                    $error("hit mismatch: expected %0b actual %0b", want, hit);
                    errors <= errors + 1;
                end
            end
        end
    end

    // Timeout guard.
    always @(posedge clk)
    begin
        if (cycles > CYCLE_CAP)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic drain();
        while (pending_rays.size() != 0 || hit_expected.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_epsilon(logic [EPS_WIDTH-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        eps_model = v;
        @(posedge clk);
    endtask

    task automatic random_phase(int n, int pct);
        idle_pct = pct;
        for (int i = 0; i < n; i++)
            pending_rays.push_back(rand_ray());
        drain();
    endtask

    initial
    begin
        logic [EPS_WIDTH-1:0] eps_set [4];
        ray_box_t r;
        eps_set = '{17'd0, 17'd65536, 17'd1, 17'd300};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items at reset epsilon: extremes, parallel axes, swapped corners.
        pending_rays.push_back(fill_ray(0, 32'sh10000, -32'sh10000, 32'sh10000));
        pending_rays.push_back(fill_ray(0, 0, -32'sh10000, 32'sh10000));
        pending_rays.push_back(fill_ray(0, 0, 32'sh10000, 32'sh20000));
        pending_rays.push_back(fill_ray(0, 6, 32'sh10000, 32'sh20000));
        pending_rays.push_back(fill_ray(0, 7, 32'sh10000, 32'sh20000));
        pending_rays.push_back(fill_ray(0, -32'sh10000, 32'sh10000, -32'sh10000));
        pending_rays.push_back(fill_ray(32'h80000000, 1, 32'h7fffffff, 32'h80000000));
        pending_rays.push_back(fill_ray(32'h7fffffff, 32'h80000000, 32'h80000000,
                                        32'h7fffffff));
        pending_rays.push_back(fill_ray(32'h80000000, 32'h7fffffff, 32'h7fffffff,
                                        32'h7fffffff));
        pending_rays.push_back(fill_ray(32'hffffffff, 32'hffffffff, 32'hffffffff,
                                        32'hffffffff));
        pending_rays.push_back(fill_ray(0, 32'sh10000, 32'sh50000, 32'sh60000));
        r = fill_ray(0, 32'sh10000, 32'sh10000, 32'sh20000);
        r.dir[1] = 0;
        r.lo[1] = -32'sh10000;
        pending_rays.push_back(r);
        r.dir[2] = -32'sh8000;
        r.lo[2] = 32'sh30000; r.hi[2] = 32'sh40000;
        pending_rays.push_back(r);
        drain();

        // Random phases across epsilon settings and idling mixes.
        random_phase(250, 0);
        for (int k = 0; k < 4; k++)
        begin
            write_epsilon(eps_set[k]);
            random_phase(150, 0);
            random_phase(60, 65);
            random_phase(60, 11);
        end
        write_epsilon(EPS_RESET);
        random_phase(60, 65);

        $display("Checked %0d results (%0d hits) over epsilon 0, 1, 7, 300 and 65536.",
                 results_seen, hits_seen);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
